@@ rtl/csp_pkg.sv @@
// shared constants, codes and beat types of the csi sequence parser
package csp_pkg;

	// default sizing
	localparam int MAX_PARAMS_DEF = 16;
	localparam int PARAM_BITS_DEF = 16;
	localparam int STORE_DEPTH_MAX = 16;

	// configuration port
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int REG_IDX_LSB = 2;
	localparam logic REG_MAX_PARAMS = 1'b0;
	localparam logic [4:0] MAX_PARAMS_RESET = 5'd16;

	// result status codes
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_UNEXPECTED = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	// byte codes
	localparam logic [7:0] CH_ESC = 8'h1B;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_MARK_LO = 8'h3C;
	localparam logic [7:0] CH_MARK_HI = 8'h3F;
	localparam logic [7:0] CH_INTER_LO = 8'h20;
	localparam logic [7:0] CH_INTER_HI = 8'h2F;
	localparam logic [7:0] CH_FINAL_LO = 8'h40;
	localparam logic [7:0] CH_FINAL_HI = 8'h7F;

	typedef enum logic [3:0] {
		PH_START = 4'b0001,
		PH_ESC   = 4'b0010,
		PH_LEAD  = 4'b0100,
		PH_BODY  = 4'b1000
	} phase_t;

	typedef enum logic [2:0] {
		RS_IDLE = 3'b001,
		RS_READ = 3'b010,
		RS_SEND = 3'b100
	} run_state_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       restart;
	} stream_beat_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [6:0]  final_byte;
		logic [7:0]  marker_byte;
		logic [7:0]  inter_byte;
		logic [4:0]  param_count;
		logic [7:0]  byte_count;
		logic [3:0]  param_index;
		logic [15:0] param_value;
		logic        last;
	} result_beat_t;

endpackage

@@ rtl/csp_stream_if.sv @@
// valid/ready stream channel carrying one payload beat
interface csp_stream_if #(
	parameter type payload_t = logic [7:0]
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/csp_ram.sv @@
// generic single-write, single-read ram with registered read data
module csp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/csi_sequence_parser_core.sv @@
// csi control sequence parser: byte parser, parameter ram and result run sequencer
// body bytes are taken back to back while no result run is pending
// a final byte starts a run of max(1, parameter count) result beats; each beat is a
// ram read state, then an output beat state that is held until the beat is taken
// input stalls from the final byte until the last beat of the run is taken
// reset clears the sequence state and parameter valid bits and sets max_params to 16
module csi_sequence_parser_core #(
	parameter int MAX_PARAMS = csp_pkg::MAX_PARAMS_DEF,
	parameter int PARAM_BITS = csp_pkg::PARAM_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [csp_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [csp_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [csp_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                            pready,
	csp_stream_if.sink                      stream,
	csp_stream_if.source                    result
);
	import csp_pkg::*;

	localparam int DEPTH = (MAX_PARAMS < STORE_DEPTH_MAX) ? MAX_PARAMS : STORE_DEPTH_MAX;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PN_W = $clog2(DEPTH + 1);
	localparam int VAL_W = (PARAM_BITS < 16) ? PARAM_BITS : 16;

	// configuration
	logic [4:0] max_params_q;
	logic       cfg_we;
	logic       cfg_idx;

	assign pready = 1'b1;
	assign cfg_idx = paddr[CFG_ADDR_W-1:REG_IDX_LSB];
	assign cfg_we = psel && penable && pwrite && pready && (cfg_idx == REG_MAX_PARAMS);
	assign prdata = (cfg_idx == REG_MAX_PARAMS) ? CFG_DATA_W'(max_params_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_params_q <= MAX_PARAMS_RESET;
		end else if (cfg_we) begin
			max_params_q <= pwdata[4:0];
		end
	end

	// effective parameter limit
	logic [PN_W-1:0] lim;

	always_comb begin
		if (max_params_q == 5'd0) begin
			lim = PN_W'(1);
		end else if (max_params_q > 5'(DEPTH)) begin
			lim = PN_W'(DEPTH);
		end else begin
			lim = PN_W'(max_params_q);
		end
	end

	// sequence state
	phase_t            phase_q;
	logic [PN_W-1:0]   pn_q;
	logic              ds_q;
	logic [7:0]        marker_q;
	logic [7:0]        inter_q;
	logic [1:0]        err_q;
	logic [7:0]        len_q;
	logic [VAL_W-1:0]  acc_q;
	logic [DEPTH-1:0]  pvalid_q;

	// run sequencer
	run_state_t        run_q;
	logic [AW-1:0]     k_q;
	logic [6:0]        fin_q;

	logic in_fire;
	logic out_fire;
	logic run_last;
	logic run_done;

	assign stream.ready = (run_q == RS_IDLE);
	assign in_fire = stream.valid && stream.ready;
	assign out_fire = result.valid && result.ready;
	assign run_done = out_fire && run_last;

	// byte step, starting from the restart-cleared view of the state
	logic [7:0]       b;
	phase_t           eff_phase, ph, phase_nx;
	logic [PN_W-1:0]  eff_pn, pn_nx;
	logic             eff_ds, ds_nx;
	logic [7:0]       eff_marker, marker_nx;
	logic [7:0]       eff_inter, inter_nx;
	logic [1:0]       eff_err, err_nx;
	logic [7:0]       eff_len, len_nx;
	logic [VAL_W-1:0] eff_acc, acc_nx;
	logic [DEPTH-1:0] eff_pvalid, pvalid_nx;
	logic [VAL_W+3:0] prod;
	logic             digit_wr;
	logic             is_final;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;

	assign b = stream.payload.data_byte;

	always_comb begin
		if (stream.payload.restart) begin
			eff_phase = PH_START;
			eff_pn = '0;
			eff_ds = 1'b0;
			eff_marker = '0;
			eff_inter = '0;
			eff_err = ST_OK;
			eff_len = '0;
			eff_acc = '0;
			eff_pvalid = '0;
		end else begin
			eff_phase = phase_q;
			eff_pn = pn_q;
			eff_ds = ds_q;
			eff_marker = marker_q;
			eff_inter = inter_q;
			eff_err = err_q;
			eff_len = len_q;
			eff_acc = acc_q;
			eff_pvalid = pvalid_q;
		end

		phase_nx = eff_phase;
		pn_nx = eff_pn;
		ds_nx = eff_ds;
		marker_nx = eff_marker;
		inter_nx = eff_inter;
		err_nx = eff_err;
		len_nx = (eff_len == 8'hFF) ? eff_len : eff_len + 8'd1;
		acc_nx = eff_acc;
		pvalid_nx = eff_pvalid;
		digit_wr = 1'b0;
		is_final = 1'b0;
		ram_waddr = eff_pn[AW-1:0];

		// acc * 10 + digit
		prod = ({4'b0, eff_acc} << 3) + ({4'b0, eff_acc} << 1) + (VAL_W + 4)'(b[3:0]);
		ph = ((eff_phase == PH_START) || (eff_phase == PH_ESC)) ? PH_LEAD : eff_phase;

		if ((eff_phase == PH_START) && (b == CH_ESC)) begin
			phase_nx = PH_ESC;
		end else if ((eff_phase == PH_ESC) && (b == CH_LBRACKET)) begin
			phase_nx = PH_LEAD;
		end else if ((b >= CH_FINAL_LO) && (b <= CH_FINAL_HI)) begin
			is_final = 1'b1;
			phase_nx = ph;
		end else if (eff_err != ST_OK) begin
			// after an error the rest is only counted
			phase_nx = PH_BODY;
		end else if ((ph == PH_LEAD) && (b >= CH_MARK_LO) && (b <= CH_MARK_HI)) begin
			marker_nx = b;
			phase_nx = PH_BODY;
		end else begin
			phase_nx = PH_BODY;
			case (b) inside
				[CH_ZERO:CH_NINE]: begin
					if (eff_pn >= lim) begin
						err_nx = ST_OVERFLOW;
					end else begin
						acc_nx = (|prod[VAL_W+3:VAL_W]) ? '1 : prod[VAL_W-1:0];
						ds_nx = 1'b1;
						digit_wr = 1'b1;
						pvalid_nx[ram_waddr] = 1'b1;
					end
				end
				CH_SEMI: begin
					if (eff_pn >= lim) begin
						err_nx = ST_OVERFLOW;
					end else begin
						pn_nx = eff_pn + PN_W'(1);
						ds_nx = 1'b0;
						acc_nx = '0;
					end
				end
				[CH_INTER_LO:CH_INTER_HI]: begin
					if (eff_inter == 8'd0) begin
						inter_nx = b;
					end else begin
						err_nx = ST_UNEXPECTED;
					end
				end
				default: begin
					err_nx = ST_UNEXPECTED;
				end
			endcase
		end
	end

	assign ram_we = in_fire && digit_wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			pn_q <= '0;
			ds_q <= 1'b0;
			marker_q <= '0;
			inter_q <= '0;
			err_q <= ST_OK;
			len_q <= '0;
			acc_q <= '0;
			pvalid_q <= '0;
		end else if (run_done) begin
			phase_q <= PH_START;
			pn_q <= '0;
			ds_q <= 1'b0;
			marker_q <= '0;
			inter_q <= '0;
			err_q <= ST_OK;
			len_q <= '0;
			acc_q <= '0;
			pvalid_q <= '0;
		end else if (in_fire) begin
			phase_q <= phase_nx;
			pn_q <= pn_nx;
			ds_q <= ds_nx;
			marker_q <= marker_nx;
			inter_q <= inter_nx;
			err_q <= err_nx;
			len_q <= len_nx;
			acc_q <= acc_nx;
			pvalid_q <= pvalid_nx;
		end
	end

	// parameter store
	logic [VAL_W-1:0] ram_rdata;

	csp_ram #(
		.WIDTH(VAL_W),
		.DEPTH(DEPTH)
	) u_param_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (acc_nx),
		.raddr (k_q),
		.rdata (ram_rdata)
	);

	// result run
	logic [PN_W-1:0] count;
	logic [PN_W-1:0] n_m1;

	assign count = (err_q == ST_UNEXPECTED) ? '0 : pn_q + PN_W'(ds_q);
	assign n_m1 = (count == '0) ? '0 : count - PN_W'(1);
	assign run_last = (PN_W'(k_q) == n_m1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= RS_IDLE;
			k_q <= '0;
		end else begin
			case (run_q)
				RS_IDLE: begin
					if (in_fire && is_final) begin
						run_q <= RS_READ;
						k_q <= '0;
					end
				end
				RS_READ: begin
					run_q <= RS_SEND;
				end
				RS_SEND: begin
					if (out_fire) begin
						if (run_last) begin
							run_q <= RS_IDLE;
						end else begin
							run_q <= RS_READ;
							k_q <= k_q + AW'(1);
						end
					end
				end
				default: begin
					run_q <= RS_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && is_final) begin
			fin_q <= b[6:0];
		end
	end

	assign result.valid = (run_q == RS_SEND);
	assign result.payload.status = err_q;
	assign result.payload.final_byte = fin_q;
	assign result.payload.marker_byte = marker_q;
	assign result.payload.inter_byte = inter_q;
	assign result.payload.param_count = 5'(count);
	assign result.payload.byte_count = len_q;
	assign result.payload.param_index = 4'(k_q);
	// entries not written in this sequence read as zero
	assign result.payload.param_value =
		((count != '0) && pvalid_q[k_q]) ? 16'(ram_rdata) : 16'd0;
	assign result.payload.last = run_last;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(stream.ready && result.valid))
		else $error("input taken while a result run is pending");

	a_read_then_send: assert property (@(posedge clk) disable iff (!arst_n)
		(run_q == RS_READ) |=> (run_q == RS_SEND))
		else $error("ram read not followed by a result beat");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (PN_W'(ram_waddr) < lim))
		else $error("parameter write beyond the limit");

	a_err_run_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && (result.payload.status == ST_UNEXPECTED)) |->
		((result.payload.param_count == 5'd0) && (result.payload.param_index == 4'd0)
		&& result.payload.last))
		else $error("error run carries parameters");

	a_run_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		run_done |=> (stream.ready && (pn_q == '0) && (len_q == 8'd0)))
		else $error("sequence state not cleared after the run");
endmodule

@@ sim/tb_csi_sequence_parser_core.sv @@
// self-checking testbench of the csi control sequence parser core
`timescale 1ns / 1ps

module tb_csi_sequence_parser_core;
	import csp_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int STORE_SLOTS = 16;
	localparam int VALUE_CEIL = 65535;
	localparam int ADDR_MAX_PARAMS = int'(REG_MAX_PARAMS) << REG_IDX_LSB;
	localparam int DIRECTED_ROWS = 36;

	typedef enum logic [1:0] {
		ROW_BEAT,
		ROW_CHECKED,
		ROW_CFG
	} row_kind_t;

	// checked rows carry the single result the final byte must produce
	typedef struct packed {
		row_kind_t   kind;
		logic [7:0]  data;
		logic        restart;
		logic [1:0]  status;
		logic [7:0]  marker;
		logic [7:0]  inter;
		logic [4:0]  count;
		logic [7:0]  length;
		logic [15:0] value;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic pready;

	csp_stream_if #(.payload_t(stream_beat_t)) stream_ch ();
	csp_stream_if #(.payload_t(result_beat_t)) result_ch ();

	csi_sequence_parser_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.stream(stream_ch),
		.result(result_ch)
	);

	always #1 clk = ~clk;

	// parser state as seen by the predictor
	phase_t      seq_phase;
	logic [15:0] seq_params [STORE_SLOTS];
	int          seq_param_num;
	logic        seq_digit;
	logic [7:0]  seq_marker;
	logic [7:0]  seq_inter;
	logic [1:0]  seq_status;
	int          seq_length;
	logic [4:0]  cfg_max_params;

	result_beat_t pending_results [$];
	int mismatches = 0;
	int items_sent = 0;
	int src_gap_max = 13;
	int snk_gap_max = 13;
	int quiet_cycles = 0;

	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{ROW_CHECKED, 8'h41, 1'b0, ST_OK, 8'h00, 8'h00, 5'd0, 8'd1, 16'd0},
		'{ROW_BEAT, CH_MARK_HI, 1'b0, ST_OK, 8'h00, 8'h00, 5'd0, 8'd0, 16'd0},
		'{ROW_BEAT, CH_NINE, 1'b0, ST_OK, 8'h00, 8'h00, 5'd0, 8'd0, 16'd0},
		'{ROW_BEAT, CH_NINE, 1'b0, ST_OK, 8'h00, 8'h00, 5'd0, 8'd0, 16'd0},
		'{ROW_BEAT, CH_NINE, 1'b0, ST_OK, 8'h00, 8'h00, 5'd0, 8'd0, 16'd0},
		'{ROW_BEAT, CH_NINE, 1'b0, ST_OK, 8'h00, 8'h00, 5'd0, 8'd0, 16'd0},
		'{ROW_BEAT, CH_NINE, 1'b0, ST_OK, 8'h00, 8'h00, 5'd0, 8'd0, 16'd0},
		// five nines saturate the parameter
		'{ROW_CHECKED, 8'h68, 1'b0, ST_OK, CH_MARK_HI, 8'h00, 5'd1, 8'd7, 16'hFFFF},
		// esc not followed by '[', then a colon and a high byte
		'{ROW_BEAT, CH_ESC, 1'b0, ST_OK, 8'h00, 8'h00, 5'd0, 8'd0, 16'd0},
		'{ROW_BEAT, 8'h3A, 1'b0, ST_OK, 8'h00, 8'h00, 5'd0, 8'd0, 16'd0},
		'{ROW_BEAT, 8'hFF, 1'b0, ST_OK, 8'h00, 8'h00, 5'd0, 8'd0, 16'd0},
		'{ROW_CHECKED, 8'h7E, 1'b0, ST_UNEXPECTED, 8'h00, 8'h00, 5'd0, 8'd4, 16'd0},
		// a bare '[' is a final byte
		'{ROW_CHECKED, CH_LBRACKET, 1'b0, ST_OK, 8'h00, 8'h00, 5'd0, 8'd1, 16'd0},
		// second intermediate
		'{ROW_BEAT, 8'h21, 1'b0, ST_OK, 8'h00, 8'h00, 5'd0, 8'd0, 16'd0},
		'{ROW_BEAT, 8'h22, 1'b0, ST_OK, 8'h00, 8'h00, 5'd0, 8'd0, 16'd0},
		'{ROW_CHECKED, 8'h70, 1'b0, ST_UNEXPECTED, 8'h00, 8'h21, 5'd0, 8'd3, 16'd0},
		// restart drops the partial sequence
		'{ROW_BEAT, CH_ESC, 1'b0, ST_OK, 8'h00, 8'h00, 5'd0, 8'd0, 16'd0},
		'{ROW_BEAT, CH_LBRACKET, 1'b0, ST_OK, 8'h00, 8'h00, 5'd0, 8'd0, 16'd0},
		'{ROW_BEAT, 8'h35, 1'b0, ST_OK, 8'h00, 8'h00, 5'd0, 8'd0, 16'd0},
		'{ROW_BEAT, 8'h37, 1'b1, ST_OK, 8'h00, 8'h00, 5'd0, 8'd0, 16'd0},
		'{ROW_CHECKED, 8'h41, 1'b0, ST_OK, 8'h00, 8'h00, 5'd1, 8'd2, 16'd7},
		// marker after the first body byte
		'{ROW_BEAT, 8'h31, 1'b0, ST_OK, 8'h00, 8'h00, 5'd0, 8'd0, 16'd0},
		'{ROW_BEAT, CH_MARK_LO, 1'b0, ST_OK, 8'h00, 8'h00, 5'd0, 8'd0, 16'd0},
		'{ROW_CHECKED, CH_FINAL_HI, 1'b0, ST_UNEXPECTED, 8'h00, 8'h00, 5'd0, 8'd3, 16'd0},
		// two parameters, one run of two beats
		'{ROW_BEAT, 8'h31, 1'b0, ST_OK, 8'h00, 8'h00, 5'd0, 8'd0, 16'd0},
		'{ROW_BEAT, CH_SEMI, 1'b0, ST_OK, 8'h00, 8'h00, 5'd0, 8'd0, 16'd0},
		'{ROW_BEAT, 8'h33, 1'b0, ST_OK, 8'h00, 8'h00, 5'd0, 8'd0, 16'd0},
		'{ROW_BEAT, CH_FINAL_LO, 1'b0, ST_OK, 8'h00, 8'h00, 5'd0, 8'd0, 16'd0},
		// max_params 0 acts as 1, so the second separator overflows
		'{ROW_CFG, 8'h00, 1'b0, ST_OK, 8'h00, 8'h00, 5'd0, 8'd0, 16'd0},
		'{ROW_BEAT, 8'h31, 1'b0, ST_OK, 8'h00, 8'h00, 5'd0, 8'd0, 16'd0},
		'{ROW_BEAT, CH_SEMI, 1'b0, ST_OK, 8'h00, 8'h00, 5'd0, 8'd0, 16'd0},
		'{ROW_BEAT, CH_SEMI, 1'b0, ST_OK, 8'h00, 8'h00, 5'd0, 8'd0, 16'd0},
		'{ROW_CHECKED, 8'h78, 1'b0, ST_OVERFLOW, 8'h00, 8'h00, 5'd1, 8'd4, 16'd1},
		// digit of a parameter beyond the limit
		'{ROW_BEAT, CH_SEMI, 1'b0, ST_OK, 8'h00, 8'h00, 5'd0, 8'd0, 16'd0},
		'{ROW_BEAT, CH_ZERO, 1'b0, ST_OK, 8'h00, 8'h00, 5'd0, 8'd0, 16'd0},
		'{ROW_CHECKED, 8'h6D, 1'b0, ST_OVERFLOW, 8'h00, 8'h00, 5'd1, 8'd3, 16'd0}
	};

	task automatic note_mismatch(input string what, input int got, input int want);
		$display("%0t mismatch: %s got %0h want %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	function automatic void clear_seq();
		seq_phase = PH_START;
		foreach (seq_params[i])
			seq_params[i] = '0;
		seq_param_num = 0;
		seq_digit = 1'b0;
		seq_marker = '0;
		seq_inter = '0;
		seq_status = ST_OK;
		seq_length = 0;
	endfunction

	function automatic int param_cap();
		int lim;
		lim = int'(cfg_max_params);
		if (lim < 1)
			lim = 1;
		if (lim > STORE_SLOTS)
			lim = STORE_SLOTS;
		return lim;
	endfunction

	// advance the parser by one byte, queueing the beats a final byte releases
	function automatic void parse_byte(input logic [7:0] b, input logic rs);
		int lim;
		int acc;
		int count;
		int n;
		result_beat_t beat;
		if (rs)
			clear_seq();
		if (seq_length < 255)
			seq_length++;
		if (seq_phase == PH_START && b == CH_ESC) begin
			seq_phase = PH_ESC;
			return;
		end
		if (seq_phase == PH_ESC && b == CH_LBRACKET) begin
			seq_phase = PH_LEAD;
			return;
		end
		if (seq_phase == PH_START || seq_phase == PH_ESC)
			seq_phase = PH_LEAD;
		if (b >= CH_FINAL_LO && b <= CH_FINAL_HI) begin
			count = 0;
			if (seq_status != ST_UNEXPECTED) begin
				count = seq_param_num + (seq_digit ? 1 : 0);
				if (count > STORE_SLOTS)
					count = STORE_SLOTS;
			end
			n = (count != 0) ? count : 1;
			for (int k = 0; k < n; k++) begin
				beat.status = seq_status;
				beat.final_byte = b[6:0];
				beat.marker_byte = seq_marker;
				beat.inter_byte = seq_inter;
				beat.param_count = 5'(count);
				beat.byte_count = 8'(seq_length);
				beat.param_index = 4'(k);
				beat.param_value = (count != 0) ? seq_params[k] : 16'd0;
				beat.last = (k == n - 1);
				pending_results.push_back(beat);
			end
			clear_seq();
			return;
		end
		// after an error only the length keeps counting
		if (seq_status != ST_OK) begin
			seq_phase = PH_BODY;
			return;
		end
		lim = param_cap();
		if (seq_phase == PH_LEAD && b >= CH_MARK_LO && b <= CH_MARK_HI) begin
			seq_marker = b;
			seq_phase = PH_BODY;
			return;
		end
		seq_phase = PH_BODY;
		if (b >= CH_ZERO && b <= CH_NINE) begin
			if (seq_param_num >= lim) begin
				seq_status = ST_OVERFLOW;
			end else begin
				acc = int'(seq_params[seq_param_num]) * 10 + int'(b - CH_ZERO);
				if (acc > VALUE_CEIL)
					acc = VALUE_CEIL;
				seq_params[seq_param_num] = 16'(acc);
				seq_digit = 1'b1;
			end
		end else if (b == CH_SEMI) begin
			if (seq_param_num + 1 > lim) begin
				seq_status = ST_OVERFLOW;
			end else begin
				seq_param_num++;
				seq_digit = 1'b0;
			end
		end else if (b >= CH_INTER_LO && b <= CH_INTER_HI) begin
			if (seq_inter == 8'h00)
				seq_inter = b;
			else
				seq_status = ST_UNEXPECTED;
		end else begin
			seq_status = ST_UNEXPECTED;
		end
	endfunction

	// entered and left at a falling edge
	task automatic send_beat(input logic [7:0] data, input logic rs);
		int gap;
		gap = (src_gap_max > 0) ? int'($urandom_range(0, src_gap_max)) : 0;
		if (gap > 0) begin
			stream_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		stream_ch.valid <= 1'b1;
		stream_ch.payload <= '{data_byte: data, restart: rs};
		do @(posedge clk); while (!stream_ch.ready);
		parse_byte(data, rs);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		stream_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		// the run sequencer may still be finishing its last beat
		repeat (4) @(negedge clk);
	endtask

	task automatic cfg_read(output logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_MAX_PARAMS[CFG_ADDR_W-1:0];
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		value = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic cfg_write(input logic [4:0] value);
		logic [CFG_DATA_W-1:0] rd;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_MAX_PARAMS[CFG_ADDR_W-1:0];
		pwdata <= CFG_DATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cfg_max_params = value;
		cfg_read(rd);
		if (rd !== CFG_DATA_W'(value))
			note_mismatch("max_params readback", int'(rd), int'(value));
	endtask

	// mostly well-formed sequences with random content, some noise and broken ones
	task automatic send_random_sequence();
		logic [7:0] seq [$];
		logic [7:0] bad;
		int lim;
		int nparams;
		int ndigits;
		lim = param_cap();
		if ($urandom_range(0, 99) < 12) begin
			repeat ($urandom_range(1, 6))
				seq.push_back(8'($urandom_range(0, 255)));
		end else begin
			if ($urandom_range(0, 1) == 1) begin
				seq.push_back(CH_ESC);
				if ($urandom_range(0, 9) != 0)
					seq.push_back(CH_LBRACKET);
			end
			if ($urandom_range(0, 3) == 0)
				seq.push_back(8'($urandom_range(CH_MARK_LO, CH_MARK_HI)));
			if ($urandom_range(0, 6) == 0)
				nparams = lim + int'($urandom_range(0, 1));
			else
				nparams = $urandom_range(0, (lim < 4) ? lim : 4);
			for (int p = 0; p < nparams; p++) begin
				if (p > 0)
					seq.push_back(CH_SEMI);
				ndigits = ($urandom_range(0, 9) == 0) ? 5 : int'($urandom_range(0, 3));
				repeat (ndigits)
					seq.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
			end
			if ($urandom_range(0, 4) == 0) begin
				case ($urandom_range(0, 4))
					0: bad = 8'($urandom_range(8'h80, 8'hFF));
					1: bad = 8'($urandom_range(8'h00, 8'h1F));
					2: bad = 8'($urandom_range(CH_MARK_LO, CH_MARK_HI));
					3: bad = CH_ESC;
					default: bad = 8'h3A;
				endcase
				seq.insert($urandom_range(0, seq.size()), bad);
			end
			if ($urandom_range(0, 3) == 0)
				seq.push_back(8'($urandom_range(CH_INTER_LO, CH_INTER_HI)));
			if ($urandom_range(0, 9) == 0)
				seq.push_back(8'($urandom_range(CH_INTER_LO, CH_INTER_HI)));
			seq.push_back(8'($urandom_range(CH_FINAL_LO, CH_FINAL_HI)));
		end
		foreach (seq[i])
			send_beat(seq[i], $urandom_range(0, 29) == 0);
		if ($urandom_range(0, 19) == 0)
			drain_results();
	endtask

	// result side: random stalls, compare each beat with the oldest prediction
	initial begin : result_sink
		int stall;
		result_beat_t got;
		result_beat_t want;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = (snk_gap_max > 0) ? int'($urandom_range(0, snk_gap_max)) : 0;
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			got = result_ch.payload;
			if (pending_results.size() == 0) begin
				note_mismatch("beat with nothing pending, final_byte", int'(got.final_byte), 0);
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status)
					note_mismatch("status", int'(got.status), int'(want.status));
				if (got.final_byte !== want.final_byte)
					note_mismatch("final_byte", int'(got.final_byte), int'(want.final_byte));
				if (got.marker_byte !== want.marker_byte)
					note_mismatch("marker_byte", int'(got.marker_byte), int'(want.marker_byte));
				if (got.inter_byte !== want.inter_byte)
					note_mismatch("inter_byte", int'(got.inter_byte), int'(want.inter_byte));
				if (got.param_count !== want.param_count)
					note_mismatch("param_count", int'(got.param_count), int'(want.param_count));
				if (got.byte_count !== want.byte_count)
					note_mismatch("byte_count", int'(got.byte_count), int'(want.byte_count));
				if (got.param_index !== want.param_index)
					note_mismatch("param_index", int'(got.param_index), int'(want.param_index));
				if (got.param_value !== want.param_value)
					note_mismatch("param_value", int'(got.param_value), int'(want.param_value));
				if (got.last !== want.last)
					note_mismatch("last", int'(got.last), int'(want.last));
			end
		end
	end

	always @(posedge clk) begin
		if ((stream_ch.valid && stream_ch.ready) || (result_ch.valid && result_ch.ready) || psel) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb_csi_sequence_parser_core: errors");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [CFG_DATA_W-1:0] rd;
		logic [4:0] cfg_plan [6];
		stim_row_t row;
		result_beat_t typed_beat;
		int target;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		stream_ch.valid = 1'b0;
		stream_ch.payload = '0;
		clear_seq();
		cfg_max_params = MAX_PARAMS_RESET;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		cfg_read(rd);
		if (rd !== CFG_DATA_W'(MAX_PARAMS_RESET))
			note_mismatch("max_params after reset", int'(rd), int'(MAX_PARAMS_RESET));

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			case (row.kind)
				ROW_CFG: begin
					drain_results();
					cfg_write(row.data[4:0]);
				end
				default: begin
					send_beat(row.data, row.restart);
					if (row.kind == ROW_CHECKED) begin
						typed_beat.status = row.status;
						typed_beat.final_byte = row.data[6:0];
						typed_beat.marker_byte = row.marker;
						typed_beat.inter_byte = row.inter;
						typed_beat.param_count = row.count;
						typed_beat.byte_count = row.length;
						typed_beat.param_index = 4'd0;
						typed_beat.param_value = row.value;
						typed_beat.last = 1'b1;
						void'(pending_results.pop_back());
						pending_results.push_back(typed_beat);
					end
				end
			endcase
		end

		cfg_plan = '{5'd16, 5'd1, 5'd31, 5'd3, 5'd0, 5'($urandom_range(2, 15))};
		target = items_sent;
		foreach (cfg_plan[p]) begin
			// every phase starts with the block drained and the sequence closed
			drain_results();
			cfg_write(cfg_plan[p]);
			case (p % 4)
				0: begin
					src_gap_max = 13;
					snk_gap_max = 13;
				end
				1: begin
					src_gap_max = 0;
					snk_gap_max = 0;
				end
				2: begin
					src_gap_max = 13;
					snk_gap_max = 0;
				end
				default: begin
					src_gap_max = 0;
					snk_gap_max = 13;
				end
			endcase
			target += 32;
			while (items_sent < target)
				send_random_sequence();
			send_beat(8'h6D, 1'b0);
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("tb_csi_sequence_parser_core: clean");
		else
			$display("tb_csi_sequence_parser_core: errors");
		$finish;
	end

endmodule
